// ----- hw/rtl/ued_pkg.sv -----
// Shared types, character codes and helpers for the unicode escape byte decoder.
package ued_pkg;

	localparam int MAX_RES = 5;
	localparam int CNT_W   = 3;

	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_U         = 8'h75;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_NINE      = 8'h39;
	localparam logic [7:0] CH_A         = 8'h61;
	localparam logic [7:0] CH_F         = 8'h66;
	localparam logic [7:0] HEX_TEN      = 8'd10;

	// One output item.
	typedef struct packed {
		logic [7:0] data;
		logic       str_end;
		logic       run_last;
		logic       warn;
	} ued_res_t;

	// Load request from the decode stage to the output buffer.
	typedef struct packed {
		logic             valid;
		logic [CNT_W-1:0] cnt;
	} ued_load_t;

	// Lowercase hex digit value; any other character counts as zero.
	function automatic logic [3:0] hexval(input logic [7:0] c);
		logic [7:0] t;
		t = 8'd0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			t = c - CH_ZERO;
		end else if (c >= CH_A && c <= CH_F) begin
			t = c - CH_A + HEX_TEN;
		end
		return t[3:0];
	endfunction

endpackage

// ----- hw/rtl/ued_outbuf.sv -----
// Output buffer: holds the items of one decoded byte, drains one per ready cycle.
module ued_outbuf (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  ued_pkg::ued_load_t                           load,
	input  ued_pkg::ued_res_t [ued_pkg::MAX_RES-1:0]     load_res,
	output logic                                         load_ok,
	output logic                                         m_tvalid,
	input  logic                                         m_tready,
	output logic [7:0]                                   m_tdata,  // out_byte
	output logic                                         m_tlast,  // out_string_end
	output logic [1:0]                                   m_tuser   // out_run_last, wide_warning
);
	import ued_pkg::*;

	ued_res_t [MAX_RES-1:0] ent_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   pop;

	assign m_tvalid = (cnt_q != '0);
	assign pop      = m_tvalid && m_tready;
	assign load_ok  = (cnt_q == '0) || (cnt_q == CNT_W'(1) && pop);

	assign m_tdata  = ent_q[0].data;
	assign m_tlast  = ent_q[0].str_end;
	assign m_tuser  = {ent_q[0].warn, ent_q[0].run_last};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load.valid) begin
			cnt_q <= load.cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// Payload: replace on load, otherwise shift toward the head on each pop.
	always_ff @(posedge clk) begin
		if (load.valid) begin
			ent_q <= load_res;
		end else if (pop) begin
			for (int i = 0; i < MAX_RES - 1; i++) begin
				ent_q[i] <= ent_q[i+1];
			end
		end
	end

endmodule

// ----- hw/rtl/unicode_escape_byte_decoder.sv -----
// Top level of the streaming unicode escape byte decoder.
//
// Takes one string byte per item on the slave stream (tlast marks the final
// byte of a string) and gives decoded bytes on the master stream. A backslash
// and 'u' open an escape; the four characters after them are consumed and the
// escape becomes one byte, 16 * hex(fifth) + hex(sixth), counting only
// lowercase hex digits (anything else is zero). tuser[1] flags an escape whose
// two high digits are not both '0'. An escape cut short by the end of the
// string comes out as its raw bytes; a backslash not followed by 'u' passes
// through raw. Each input item gives zero to five output items, and tuser[0]
// marks the last one caused by that input item. An accepted item is held in
// the input register, where it is decoded in one pass; once the output buffer
// can take its results they are loaded there, and the first is then on the
// master stream. The output buffer drains one item per cycle while m_tready
// is high, and the input register hands its item over only when the buffer is
// empty or its last item is being taken, so an item that produces several
// results holds the input until its last result is being taken; items that
// produce zero or one result are accepted every cycle while m_tready is high.
// s_tready follows m_tready combinationally through that check.
module unicode_escape_byte_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // in_byte
	input  logic       s_tlast,   // in_final
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // out_byte
	output logic       m_tlast,   // out_string_end
	output logic [1:0] m_tuser    // out_run_last, wide_warning
);
	import ued_pkg::*;

	// Input register stage.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       final_s1;

	// Escape prefix held across items.
	logic [CNT_W-1:0] pc_q;
	logic [7:0]       pend_q [MAX_RES];

	// Decode results.
	ued_res_t [MAX_RES-1:0] res;
	logic [CNT_W-1:0]       n_res;
	logic [CNT_W-1:0]       pc_d;
	logic                   wr_en;
	logic [CNT_W-1:0]       wr_idx;
	ued_load_t              load;
	logic                   load_ok;
	logic                   adv;

	// Advance the input stage when the output buffer can take its results.
	assign adv      = valid_s1 && load_ok;
	assign s_tready = !valid_s1 || load_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata;
			final_s1 <= s_tlast;
		end
	end

	// Single-pass decode of the staged byte against the held prefix.
	always_comb begin
		res    = '0;
		n_res  = '0;
		pc_d   = '0;
		wr_en  = 1'b0;
		wr_idx = pc_q;
		case (pc_q)
			CNT_W'(1), CNT_W'(2), CNT_W'(3), CNT_W'(4): begin
				if (final_s1) begin
					// Escape cut short: flush the held bytes and this one raw.
					for (int i = 0; i < MAX_RES - 1; i++) begin
						if (CNT_W'(i) < pc_q) begin
							res[i].data = pend_q[i];
						end
					end
					res[pc_q].data    = byte_s1;
					res[pc_q].str_end = 1'b1;
					n_res             = pc_q + CNT_W'(1);
				end else if (pc_q == CNT_W'(1) && byte_s1 != CH_U) begin
					// Backslash without 'u': emit it, then treat this byte as fresh.
					res[0].data = pend_q[0];
					if (byte_s1 == CH_BACKSLASH) begin
						n_res  = CNT_W'(1);
						pc_d   = CNT_W'(1);
						wr_en  = 1'b1;
						wr_idx = '0;
					end else begin
						res[1].data = byte_s1;
						n_res       = CNT_W'(2);
					end
				end else begin
					// Hold the byte and advance through the escape.
					wr_en = 1'b1;
					pc_d  = pc_q + CNT_W'(1);
				end
			end
			CNT_W'(5): begin
				res[0].data    = {hexval(pend_q[4]), hexval(byte_s1)};
				res[0].str_end = final_s1;
				res[0].warn    = (pend_q[2] != CH_ZERO) || (pend_q[3] != CH_ZERO);
				n_res          = CNT_W'(1);
			end
			default: begin
				if (byte_s1 == CH_BACKSLASH && !final_s1) begin
					wr_en  = 1'b1;
					wr_idx = '0;
					pc_d   = CNT_W'(1);
				end else begin
					res[0].data    = byte_s1;
					res[0].str_end = final_s1;
					n_res          = CNT_W'(1);
				end
			end
		endcase
		// Mark the last result of this item.
		for (int i = 0; i < MAX_RES; i++) begin
			res[i].run_last = (n_res == CNT_W'(i + 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
		end else if (adv) begin
			pc_q <= pc_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && wr_en) begin
			pend_q[wr_idx] <= byte_s1;
		end
	end

	assign load.valid = adv;
	assign load.cnt   = n_res;

	ued_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.load_res (res),
		.load_ok  (load_ok),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	// The held prefix never grows past a full escape.
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= CNT_W'(5))
		else $error("escape prefix count out of range");

	// Nothing stays held after the final byte of a string.
	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && final_s1 |=> pc_q == '0)
		else $error("prefix held across string end");

	// A completed escape yields exactly one result.
	a_escape_one: assert property (@(posedge clk) disable iff (!arst_n)
		adv && pc_q == CNT_W'(5) |-> n_res == CNT_W'(1))
		else $error("escape did not give one result");

	// A non-final byte never flags the string end on its first two results.
	a_end_only_final: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !final_s1 |-> !res[0].str_end && !res[1].str_end)
		else $error("string end flagged on non-final byte");

endmodule
